// File: rtl/sfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and constants of the stuffed frame receiver
// Holds field widths, event kind codes, control code checks and the
// structs that pass configuration and events between the modules.
// ----------------------------------------------------------------------------
package sfr_pkg;

    // Field widths
    localparam int ByteW = 8;
    localparam int KindW = 2;
    localparam int LenW  = 10;
    localparam int IdxW  = 3;

    // Largest number of bytes stored in one info frame, BCC2 included
    localparam int MaxStored = 1024;
    localparam int CntW      = $clog2(MaxStored + 1);

    // Configuration register indexes
    localparam logic [IdxW-1:0] R_FLAG     = 3'd0;
    localparam logic [IdxW-1:0] R_ESCAPE   = 3'd1;
    localparam logic [IdxW-1:0] R_ESC_FLAG = 3'd2;
    localparam logic [IdxW-1:0] R_ESC_ESC  = 3'd3;
    localparam logic [IdxW-1:0] R_SENDER   = 3'd4;
    localparam logic [IdxW-1:0] R_RECEIVER = 3'd5;

    // Event kinds
    localparam logic [KindW-1:0] EV_PAYLOAD   = 2'd0;
    localparam logic [KindW-1:0] EV_CTRL_DONE = 2'd1;
    localparam logic [KindW-1:0] EV_INFO_DONE = 2'd2;
    localparam logic [KindW-1:0] EV_OVERFLOW  = 2'd3;

    // Control field codes
    localparam logic [ByteW-1:0] C_SET    = 8'h03;
    localparam logic [ByteW-1:0] C_DISC   = 8'h0B;
    localparam logic [ByteW-1:0] C_UA     = 8'h07;
    localparam logic [ByteW-1:0] C_RR0    = 8'h05;
    localparam logic [ByteW-1:0] C_RR1    = 8'h85;
    localparam logic [ByteW-1:0] C_REJ0   = 8'h01;
    localparam logic [ByteW-1:0] C_REJ1   = 8'h81;
    localparam logic [ByteW-1:0] C_INFO0  = 8'h00;
    localparam logic [ByteW-1:0] C_INFO1  = 8'h40;

    // Line configuration
    typedef struct packed {
        logic [ByteW-1:0] flag_byte;
        logic [ByteW-1:0] escape_byte;
        logic [ByteW-1:0] escaped_flag_byte;
        logic [ByteW-1:0] escaped_escape_byte;
        logic [ByteW-1:0] sender_address;
        logic [ByteW-1:0] receiver_address;
    } cfg_t;

    // One reported event
    typedef struct packed {
        logic [KindW-1:0] kind;
        logic [ByteW-1:0] payload;
        logic [ByteW-1:0] address;
        logic [ByteW-1:0] control;
        logic             good;
        logic [LenW-1:0]  length;
    } event_t;

    function automatic logic is_ctrl_code(input logic [ByteW-1:0] c);
        return (c == C_SET) || (c == C_DISC) || (c == C_UA) || (c == C_RR0) ||
               (c == C_RR1) || (c == C_REJ0) || (c == C_REJ1);
    endfunction

    function automatic logic is_info_code(input logic [ByteW-1:0] c);
        return (c == C_INFO0) || (c == C_INFO1);
    endfunction

endpackage

// File: rtl/stuffed_frame_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stuffed_frame_receiver: flag-delimited, byte-stuffed frame receiver
// Parses line bytes into frames, destuffs info payloads one byte late and
// reports payload bytes, frame completions and overflow as events.
//
//   channel   handshake            payload
//   in        in_valid/in_stall    rx_byte
//   out       out_valid/out_stall  event_kind, payload_byte, frame_address,
//                                  frame_control, bcc2_good, payload_length
//   cfg       cfg_we               cfg_index, cfg_data
//
// One line byte per cycle while in_stall is low; its event, if any, appears
// in the output register in the cycle after the transfer. Input stalls only
// while an event sits in the output register and out_stall is high. Reset
// returns the parser to the start phase and loads the default line codes
// and addresses.
// ----------------------------------------------------------------------------
module stuffed_frame_receiver (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [sfr_pkg::ByteW-1:0] rx_byte,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [sfr_pkg::KindW-1:0] event_kind,
    output logic [sfr_pkg::ByteW-1:0] payload_byte,
    output logic [sfr_pkg::ByteW-1:0] frame_address,
    output logic [sfr_pkg::ByteW-1:0] frame_control,
    output logic                      bcc2_good,
    output logic [sfr_pkg::LenW-1:0]  payload_length,
    input  logic                      cfg_we,
    input  logic [sfr_pkg::IdxW-1:0]  cfg_index,
    input  logic [sfr_pkg::ByteW-1:0] cfg_data
);

    sfr_pkg::cfg_t   cfg_reg;
    sfr_pkg::event_t ev;
    sfr_pkg::event_t ev_out_reg;
    logic            ev_valid;
    logic            out_valid_reg;
    logic            in_xfer;

    assign in_stall = out_valid_reg && out_stall;
    assign in_xfer  = in_valid && !in_stall;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.flag_byte           <= 8'h7E;
            cfg_reg.escape_byte         <= 8'h7D;
            cfg_reg.escaped_flag_byte   <= 8'h5E;
            cfg_reg.escaped_escape_byte <= 8'h5D;
            cfg_reg.sender_address      <= 8'h03;
            cfg_reg.receiver_address    <= 8'h01;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sfr_pkg::R_FLAG:     cfg_reg.flag_byte           <= cfg_data;
                sfr_pkg::R_ESCAPE:   cfg_reg.escape_byte         <= cfg_data;
                sfr_pkg::R_ESC_FLAG: cfg_reg.escaped_flag_byte   <= cfg_data;
                sfr_pkg::R_ESC_ESC:  cfg_reg.escaped_escape_byte <= cfg_data;
                sfr_pkg::R_SENDER:   cfg_reg.sender_address      <= cfg_data;
                sfr_pkg::R_RECEIVER: cfg_reg.receiver_address    <= cfg_data;
                default:             ;
            endcase
        end
    end

    sfr_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (in_xfer),
        .rx_byte  (rx_byte),
        .cfg      (cfg_reg),
        .ev_valid (ev_valid),
        .ev       (ev)
    );

    // Output register: load on a new event, drop after its transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_xfer && ev_valid)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer && ev_valid)
            ev_out_reg <= ev;
    end

    assign out_valid      = out_valid_reg;
    assign event_kind     = ev_out_reg.kind;
    assign payload_byte   = ev_out_reg.payload;
    assign frame_address  = ev_out_reg.address;
    assign frame_control  = ev_out_reg.control;
    assign bcc2_good      = ev_out_reg.good;
    assign payload_length = ev_out_reg.length;

endmodule

// File: rtl/sfr_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_parser: frame parse state machine
// Moves the parse state one line byte per transfer, destuffs the info
// payload, tracks the running XOR and byte count, and flags an event.
// ----------------------------------------------------------------------------
module sfr_parser (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step,
    input  logic [sfr_pkg::ByteW-1:0] rx_byte,
    input  sfr_pkg::cfg_t            cfg,
    output logic                     ev_valid,
    output sfr_pkg::event_t          ev
);

    typedef enum logic [2:0] {
        PH_START,
        PH_FLAG,
        PH_ADDR,
        PH_CTRL,
        PH_BCC1,
        PH_DATA
    } phase_t;

    localparam logic [sfr_pkg::CntW-1:0] MaxCnt = sfr_pkg::CntW'(sfr_pkg::MaxStored);

    phase_t                      phase_reg, phase_next;
    logic                        esc_reg, esc_next;
    logic [sfr_pkg::ByteW-1:0]   addr_reg, addr_next;
    logic [sfr_pkg::ByteW-1:0]   ctrl_reg, ctrl_next;
    logic [sfr_pkg::ByteW-1:0]   hbyte_reg, hbyte_next;
    logic                        hv_reg, hv_next;
    logic [sfr_pkg::ByteW-1:0]   xor_reg, xor_next;
    logic [sfr_pkg::CntW-1:0]    cnt_reg, cnt_next;

    // Working copies: a fresh frame starts from cleared values
    logic                        esc_eff;
    logic                        hv_eff;
    logic [sfr_pkg::ByteW-1:0]   xor_eff;
    logic [sfr_pkg::CntW-1:0]    cnt_eff;
    logic                        do_data;
    logic                        do_store;
    logic [sfr_pkg::ByteW-1:0]   store_val;
    logic [sfr_pkg::CntW-1:0]    cnt_dec;
    logic [sfr_pkg::CntW+sfr_pkg::LenW-1:0] len_wide;

    assign cnt_dec  = cnt_eff - sfr_pkg::CntW'(1);
    assign len_wide = {{sfr_pkg::LenW{1'b0}}, cnt_dec};

    // Next state and event for one line byte
    always_comb
    begin
        phase_next = phase_reg;
        esc_next   = esc_reg;
        addr_next  = addr_reg;
        ctrl_next  = ctrl_reg;
        hbyte_next = hbyte_reg;
        hv_next    = hv_reg;
        xor_next   = xor_reg;
        cnt_next   = cnt_reg;
        esc_eff    = esc_reg;
        hv_eff     = hv_reg;
        xor_eff    = xor_reg;
        cnt_eff    = cnt_reg;
        do_data    = 1'b0;
        do_store   = 1'b0;
        store_val  = rx_byte;
        ev_valid   = 1'b0;
        ev.kind    = sfr_pkg::EV_PAYLOAD;
        ev.payload = '0;
        ev.address = addr_reg;
        ev.control = ctrl_reg;
        ev.good    = 1'b0;
        ev.length  = '0;

        if (step)
        begin
            unique case (phase_reg)
                PH_START:
                begin
                    if (rx_byte == cfg.flag_byte)
                        phase_next = PH_FLAG;
                end
                PH_FLAG:
                begin
                    if (rx_byte == cfg.sender_address || rx_byte == cfg.receiver_address)
                    begin
                        addr_next  = rx_byte;
                        phase_next = PH_ADDR;
                    end
                    else if (rx_byte != cfg.flag_byte)
                        phase_next = PH_START;
                end
                PH_ADDR:
                begin
                    if (sfr_pkg::is_ctrl_code(rx_byte) || sfr_pkg::is_info_code(rx_byte))
                    begin
                        ctrl_next  = rx_byte;
                        phase_next = PH_CTRL;
                    end
                    else
                        phase_next = (rx_byte == cfg.flag_byte) ? PH_FLAG : PH_START;
                end
                PH_CTRL:
                begin
                    if ((addr_reg ^ ctrl_reg) == rx_byte)
                        phase_next = PH_BCC1;
                    else
                        phase_next = (rx_byte == cfg.flag_byte) ? PH_FLAG : PH_START;
                end
                PH_BCC1:
                begin
                    if (rx_byte == cfg.flag_byte)
                    begin
                        phase_next = PH_START;
                        if (sfr_pkg::is_ctrl_code(ctrl_reg))
                        begin
                            ev_valid = 1'b1;
                            ev.kind  = sfr_pkg::EV_CTRL_DONE;
                        end
                    end
                    else if (!sfr_pkg::is_info_code(ctrl_reg))
                        phase_next = PH_START;
                    else
                    begin
                        // open the payload with cleared frame state
                        phase_next = PH_DATA;
                        esc_eff    = 1'b0;
                        hv_eff     = 1'b0;
                        xor_eff    = '0;
                        cnt_eff    = '0;
                        esc_next   = 1'b0;
                        hv_next    = 1'b0;
                        xor_next   = '0;
                        cnt_next   = '0;
                        do_data    = 1'b1;
                    end
                end
                PH_DATA:
                    do_data = 1'b1;
                default:
                    phase_next = PH_START;
            endcase

            // Destuff a payload byte or close the frame
            if (do_data)
            begin
                if (esc_eff)
                begin
                    esc_next = 1'b0;
                    if (rx_byte == cfg.escaped_escape_byte)
                    begin
                        do_store  = 1'b1;
                        store_val = cfg.escape_byte;
                    end
                    else if (rx_byte == cfg.escaped_flag_byte)
                    begin
                        do_store  = 1'b1;
                        store_val = cfg.flag_byte;
                    end
                    else
                        phase_next = (rx_byte == cfg.flag_byte) ? PH_FLAG : PH_START;
                end
                else if (rx_byte == cfg.escape_byte)
                    esc_next = 1'b1;
                else if (rx_byte == cfg.flag_byte)
                begin
                    phase_next = PH_START;
                    ev_valid   = 1'b1;
                    ev.kind    = sfr_pkg::EV_INFO_DONE;
                    if (hv_eff && cnt_eff != '0)
                    begin
                        ev.good   = (xor_eff == hbyte_reg);
                        ev.length = len_wide[sfr_pkg::LenW-1:0];
                    end
                end
                else
                    do_store = 1'b1;
            end

            // Store one byte; release the held one
            if (do_store)
            begin
                if (cnt_eff >= MaxCnt)
                begin
                    phase_next = PH_START;
                    esc_next   = 1'b0;
                    hv_next    = 1'b0;
                    ev_valid   = 1'b1;
                    ev.kind    = sfr_pkg::EV_OVERFLOW;
                end
                else
                begin
                    if (hv_eff)
                    begin
                        xor_next   = xor_eff ^ hbyte_reg;
                        ev_valid   = 1'b1;
                        ev.kind    = sfr_pkg::EV_PAYLOAD;
                        ev.payload = hbyte_reg;
                    end
                    hbyte_next = store_val;
                    hv_next    = 1'b1;
                    cnt_next   = cnt_eff + sfr_pkg::CntW'(1);
                end
            end
        end
    end

    // Hold parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            esc_reg   <= 1'b0;
            addr_reg  <= '0;
            ctrl_reg  <= '0;
            hbyte_reg <= '0;
            hv_reg    <= 1'b0;
            xor_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            esc_reg   <= esc_next;
            addr_reg  <= addr_next;
            ctrl_reg  <= ctrl_next;
            hbyte_reg <= hbyte_next;
            hv_reg    <= hv_next;
            xor_reg   <= xor_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Checks
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= MaxCnt)
        else $error("stored count above limit");

    a_held_counted: assert property (@(posedge clk) disable iff (!rst_n)
        hv_reg |-> cnt_reg != '0)
        else $error("held byte without stored count");

    a_esc_in_data: assert property (@(posedge clk) disable iff (!rst_n)
        esc_reg |-> phase_reg == PH_DATA)
        else $error("escape pending outside payload");

    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(phase_reg) && $stable(cnt_reg) && $stable(xor_reg))
        else $error("parse state moved without a transfer");

endmodule

// File: bench/stuffed_frame_receiver_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stuffed_frame_receiver_tb: self-checking bench of the stuffed frame receiver
// Feeds line bytes through the valid/stall input, mirrors the frame parser
// in a scoreboard class and checks every reported event field by field.
// Runs directed frames, random frames, broken frames and line noise under
// several line code settings.
// ----------------------------------------------------------------------------
module stuffed_frame_receiver_tb;
    import sfr_pkg::*;

    // Unused indexes of the configuration port
    localparam logic [IdxW-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [IdxW-1:0] REG_SPARE_HI = 3'd7;

    typedef enum logic [2:0] {
        HUNT,
        GOT_FLAG,
        GOT_ADDR,
        GOT_CTRL,
        GOT_BCC1,
        IN_DATA
    } rx_phase_t;

    // ------------------------------------------------------------------------
    // Scoreboard: parser mirror plus the queue of events still to arrive
    // ------------------------------------------------------------------------
    class frame_board_t;
        cfg_t             regs;
        rx_phase_t        phase;
        bit               esc_pending;
        logic [ByteW-1:0] hold_addr;
        logic [ByteW-1:0] hold_ctrl;
        logic [ByteW-1:0] hold_data;
        bit               hold_valid;
        logic [ByteW-1:0] xor_sum;
        int unsigned      stored;
        event_t           expected_events[$];
        int               mismatches;

        function new();
            regs = '{flag_byte: 8'h7E, escape_byte: 8'h7D, escaped_flag_byte: 8'h5E,
                     escaped_escape_byte: 8'h5D, sender_address: 8'h03,
                     receiver_address: 8'h01};
            phase       = HUNT;
            esc_pending = 0;
            hold_addr   = '0;
            hold_ctrl   = '0;
            hold_data   = '0;
            hold_valid  = 0;
            xor_sum     = '0;
            stored      = 0;
            mismatches  = 0;
        endfunction

        function void set_reg(logic [IdxW-1:0] idx, logic [ByteW-1:0] v);
            case (idx)
                R_FLAG:     regs.flag_byte = v;
                R_ESCAPE:   regs.escape_byte = v;
                R_ESC_FLAG: regs.escaped_flag_byte = v;
                R_ESC_ESC:  regs.escaped_escape_byte = v;
                R_SENDER:   regs.sender_address = v;
                R_RECEIVER: regs.receiver_address = v;
                default: ;
            endcase
        endfunction

        function bit is_control(logic [ByteW-1:0] c);
            case (c)
                C_SET, C_DISC, C_UA, C_RR0, C_RR1, C_REJ0, C_REJ1: return 1;
                default: return 0;
            endcase
        endfunction

        function bit is_info(logic [ByteW-1:0] c);
            return (c == C_INFO0) || (c == C_INFO1);
        endfunction

        function void add_event(logic [KindW-1:0] kind, logic [ByteW-1:0] pay,
                                logic good, logic [LenW-1:0] len);
            event_t e;
            e.kind    = kind;
            e.payload = pay;
            e.address = hold_addr;
            e.control = hold_ctrl;
            e.good    = good;
            e.length  = len;
            expected_events.push_back(e);
        endfunction

        // Keep one destuffed byte; release the one held before it
        function void store_byte(logic [ByteW-1:0] b);
            if (stored >= MaxStored)
            begin
                phase       = HUNT;
                esc_pending = 0;
                hold_valid  = 0;
                add_event(EV_OVERFLOW, '0, 1'b0, '0);
                return;
            end
            if (hold_valid)
            begin
                xor_sum ^= hold_data;
                add_event(EV_PAYLOAD, hold_data, 1'b0, '0);
            end
            hold_data  = b;
            hold_valid = 1;
            stored++;
        endfunction

        function void take_data(logic [ByteW-1:0] c);
            if (esc_pending)
            begin
                esc_pending = 0;
                if (c == regs.escaped_escape_byte)
                    store_byte(regs.escape_byte);
                else if (c == regs.escaped_flag_byte)
                    store_byte(regs.flag_byte);
                else
                    phase = (c == regs.flag_byte) ? GOT_FLAG : HUNT;
            end
            else if (c == regs.escape_byte)
            begin
                esc_pending = 1;
            end
            else if (c == regs.flag_byte)
            begin
                phase = HUNT;
                if (stored == 0 || !hold_valid)
                    add_event(EV_INFO_DONE, '0, 1'b0, '0);
                else
                    add_event(EV_INFO_DONE, '0, xor_sum == hold_data,
                              LenW'(stored - 1));
            end
            else
            begin
                store_byte(c);
            end
        endfunction

        // Advance the parser by one accepted line byte
        function void note_line_byte(logic [ByteW-1:0] c);
            case (phase)
                HUNT:
                begin
                    if (c == regs.flag_byte)
                        phase = GOT_FLAG;
                end
                GOT_FLAG:
                begin
                    if (c == regs.sender_address || c == regs.receiver_address)
                    begin
                        hold_addr = c;
                        phase     = GOT_ADDR;
                    end
                    else if (c != regs.flag_byte)
                    begin
                        phase = HUNT;
                    end
                end
                GOT_ADDR:
                begin
                    if (is_control(c) || is_info(c))
                    begin
                        hold_ctrl = c;
                        phase     = GOT_CTRL;
                    end
                    else
                    begin
                        phase = (c == regs.flag_byte) ? GOT_FLAG : HUNT;
                    end
                end
                GOT_CTRL:
                begin
                    if ((hold_addr ^ hold_ctrl) == c)
                        phase = GOT_BCC1;
                    else
                        phase = (c == regs.flag_byte) ? GOT_FLAG : HUNT;
                end
                GOT_BCC1:
                begin
                    if (c == regs.flag_byte)
                    begin
                        phase = HUNT;
                        if (is_control(hold_ctrl))
                            add_event(EV_CTRL_DONE, '0, 1'b0, '0);
                    end
                    else if (!is_info(hold_ctrl))
                    begin
                        phase = HUNT;
                    end
                    else
                    begin
                        phase       = IN_DATA;
                        esc_pending = 0;
                        hold_valid  = 0;
                        xor_sum     = '0;
                        stored      = 0;
                        take_data(c);
                    end
                end
                IN_DATA: take_data(c);
                default: phase = HUNT;
            endcase
        endfunction

        function void compare_field(string what, int unsigned want, int unsigned got);
            if (want != got)
            begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, what, want, got);
            end
        endfunction

        function void check_event(event_t got);
            event_t want;
            if (expected_events.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected event, expected none, actual kind %0d",
                         $time, got.kind);
                return;
            end
            want = expected_events.pop_front();
            compare_field("event_kind", want.kind, got.kind);
            compare_field("payload_byte", want.payload, got.payload);
            compare_field("frame_address", want.address, got.address);
            compare_field("frame_control", want.control, got.control);
            compare_field("bcc2_good", want.good, got.good);
            compare_field("payload_length", want.length, got.length);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block under test
    // ------------------------------------------------------------------------
    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    logic [ByteW-1:0] rx_byte;
    logic             out_valid;
    logic             out_stall;
    logic [KindW-1:0] event_kind;
    logic [ByteW-1:0] payload_byte;
    logic [ByteW-1:0] frame_address;
    logic [ByteW-1:0] frame_control;
    logic             bcc2_good;
    logic [LenW-1:0]  payload_length;
    logic             cfg_we;
    logic [IdxW-1:0]  cfg_index;
    logic [ByteW-1:0] cfg_data;

    stuffed_frame_receiver dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .event_kind     (event_kind),
        .payload_byte   (payload_byte),
        .frame_address  (frame_address),
        .frame_control  (frame_control),
        .bcc2_good      (bcc2_good),
        .payload_length (payload_length),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    frame_board_t     sb = new();
    logic [ByteW-1:0] line_q[$];
    bit               no_idle = 0;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Time limit
    initial
    begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Event side: check each transfer, then hold off a random number of cycles
    // ------------------------------------------------------------------------
    initial
    begin
        event_t got;
        int     stall_left;
        stall_left = 0;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                got.kind    = event_kind;
                got.payload = payload_byte;
                got.address = frame_address;
                got.control = frame_control;
                got.good    = bcc2_good;
                got.length  = payload_length;
                sb.check_event(got);
                stall_left = no_idle ? 0 : $urandom_range(0, 16);
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Line side
    // ------------------------------------------------------------------------

    // Offer one byte after a random gap and hold it until the transfer
    task automatic send_byte(input logic [ByteW-1:0] b);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_line_byte(b);
    endtask

    task automatic send_line();
        foreach (line_q[i]) send_byte(line_q[i]);
        line_q.delete();
    endtask

    // Drop valid and hold until every expected event has arrived
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_events.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IdxW-1:0] idx, input logic [ByteW-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        sb.set_reg(idx, v);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_regs(input logic [ByteW-1:0] f, e, ef, ee, sa, ra);
        wait_drained();
        repeat (4) @(posedge clk);
        write_reg(R_FLAG, f);
        write_reg(R_ESCAPE, e);
        write_reg(R_ESC_FLAG, ef);
        write_reg(R_ESC_ESC, ee);
        write_reg(R_SENDER, sa);
        write_reg(R_RECEIVER, ra);
    endtask

    function automatic void put_stuffed(logic [ByteW-1:0] b);
        if (b == sb.regs.escape_byte)
        begin
            line_q.push_back(sb.regs.escape_byte);
            line_q.push_back(sb.regs.escaped_escape_byte);
        end
        else if (b == sb.regs.flag_byte)
        begin
            line_q.push_back(sb.regs.escape_byte);
            line_q.push_back(sb.regs.escaped_flag_byte);
        end
        else
        begin
            line_q.push_back(b);
        end
    endfunction

    // Queue one frame under the current line codes; plen < 0 leaves out payload and BCC2
    function automatic void queue_frame(bit info, int plen, bit bad_check);
        logic [ByteW-1:0] addr;
        logic [ByteW-1:0] ctrl;
        logic [ByteW-1:0] sum;
        logic [ByteW-1:0] b;
        addr = $urandom_range(0, 1) ? sb.regs.sender_address : sb.regs.receiver_address;
        if (info)
            ctrl = $urandom_range(0, 1) ? C_INFO1 : C_INFO0;
        else
            case ($urandom_range(0, 6))
                0: ctrl = C_SET;
                1: ctrl = C_DISC;
                2: ctrl = C_UA;
                3: ctrl = C_RR0;
                4: ctrl = C_RR1;
                5: ctrl = C_REJ0;
                default: ctrl = C_REJ1;
            endcase
        line_q.push_back(sb.regs.flag_byte);
        line_q.push_back(addr);
        line_q.push_back(ctrl);
        line_q.push_back(addr ^ ctrl);
        if (info && plen >= 0)
        begin
            sum = '0;
            for (int i = 0; i < plen; i++)
            begin
                case ($urandom_range(0, 7))
                    0: b = sb.regs.flag_byte;
                    1: b = sb.regs.escape_byte;
                    default: b = ByteW'($urandom);
                endcase
                sum ^= b;
                put_stuffed(b);
            end
            put_stuffed(bad_check ? sum ^ ByteW'($urandom_range(1, 255)) : sum);
        end
        line_q.push_back(sb.regs.flag_byte);
    endfunction

    // Mostly good frames, mixed with broken frames and line noise
    task automatic random_traffic(input int n_items);
        int sent;
        int pick;
        int idx;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 9) == 0)
                no_idle = !no_idle;
            if ($urandom_range(0, 24) == 0)
                wait_drained();
            pick = $urandom_range(0, 99);
            if (pick < 85)
            begin
                queue_frame($urandom_range(0, 1), $urandom_range(0, 13) - 1,
                            $urandom_range(0, 6) == 0);
                if (pick >= 70)
                begin
                    // corrupt, cut short or break an escape inside the frame
                    idx = $urandom_range(1, line_q.size() - 1);
                    case ($urandom_range(0, 2))
                        0: line_q[idx] = ByteW'($urandom);
                        1: line_q = line_q[0:idx-1];
                        default:
                        begin
                            line_q.insert(idx, sb.regs.escape_byte);
                            line_q.insert(idx + 1, ByteW'($urandom));
                        end
                    endcase
                end
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    line_q.push_back($urandom_range(0, 3) == 0 ? sb.regs.flag_byte
                                                               : ByteW'($urandom));
            end
            sent += line_q.size();
            send_line();
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        rx_byte   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames under the reset line codes
        line_q = '{8'h7E, 8'h03, C_SET, 8'h00, 8'h7E,
                   8'h7E, 8'h01, C_INFO1, 8'h41, 8'h7D, 8'h5E, 8'h7D, 8'h5D,
                   8'hFF, 8'h00, 8'hFC, 8'h7E,
                   8'h7E, 8'h03, C_INFO0, 8'h03, 8'h7E,
                   8'h7E, 8'h03, C_INFO1, 8'h43, 8'hAA, 8'h7E,
                   8'h7E, 8'h03, C_INFO0, 8'h03, 8'h7D, 8'h7E,
                   8'h01, C_DISC, 8'h0A, 8'h7E,
                   8'h7E, 8'h01, C_INFO0, 8'h01, 8'h7D, 8'h11};
        send_line();
        random_traffic(100);

        // Extreme code values; writes to the spare indexes must be ignored
        load_regs(8'h00, 8'hFF, 8'h01, 8'hFE, 8'h80, 8'h7F);
        write_reg(REG_SPARE_LO, 8'hFF);
        write_reg(REG_SPARE_HI, 8'h00);
        random_traffic(90);

        // Colliding codes: address and escape over flag, escaped pair tie
        load_regs(8'h55, 8'h55, 8'h20, 8'h20, 8'h55, 8'hAA);
        random_traffic(70);

        // Opposite extremes, receiver address equal to the flag
        load_regs(8'hFF, 8'h00, 8'h80, 8'h7F, 8'h00, 8'hFF);
        random_traffic(90);

        // Back to reset codes
        load_regs(8'h7E, 8'h7D, 8'h5E, 8'h5D, 8'h03, 8'h01);
        random_traffic(40);

        wait_drained();
        repeat (10) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_events.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: sim.f
rtl/sfr_pkg.sv
rtl/sfr_parser.sv
rtl/stuffed_frame_receiver.sv
bench/stuffed_frame_receiver_tb.sv
